[rtl/sfdl_pkg.sv]
// Shared types, constants and helpers for the stereo feedback delay line.
`default_nettype none
package sfdl_pkg;

   localparam int SAMPLE_BITS         = 16;
   localparam int DAMP_EXTRA_BITS     = 8;
   localparam int DAMP_W              = SAMPLE_BITS + DAMP_EXTRA_BITS;
   localparam int DELAY_DEPTH_DEFAULT = 131072;

   // shared multiplier: A operand holds a difference of damping-scale values
   localparam int MUL_A_W = DAMP_W + 1;
   localparam int MUL_B_W = 18;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = PROD_W + 1;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_SAMPLES  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_FRACTION = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK_GAIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WET_MIX        = 3'd4;

   localparam logic [1:0]  CHANNELS_MONO = 2'd1;

   localparam logic [1:0]  RST_CHANNEL_COUNT  = 2'd2;
   localparam logic [16:0] RST_DELAY_SAMPLES  = 17'd19200;
   localparam logic [15:0] RST_DELAY_FRACTION = 16'd0;
   localparam logic [15:0] RST_FEEDBACK_GAIN  = 16'd22938;
   localparam logic [16:0] RST_WET_MIX        = 17'd32768;

   localparam logic [15:0] FB_MAX_Q16   = 16'd62259;
   localparam logic [16:0] MIX_ONE_Q16  = 17'd65536;
   // 0.3 in Q0.16; the 0.7 weight is 65536 minus this
   localparam logic [15:0] DAMP_NEW_Q16 = 16'd19661;

   localparam logic signed [ACC_W-1:0] SAMPLE_MAX_ACC = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [ACC_W-1:0] SAMPLE_MIN_ACC = -SAMPLE_MAX_ACC - 1;

   typedef enum logic [1:0] {
      OP_BLEND,
      OP_FEEDBACK,
      OP_DAMP,
      OP_MIX
   } op_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_in;
      logic signed [SAMPLE_BITS-1:0] right_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } rsp_type;

   typedef struct packed {
      logic   clr_we;
      logic   in_load;
      logic   addr_load;
      logic   rd_en;
      logic   mul_en;
      logic   add_en;
      logic   wr_en;
      logic   out_load;
      op_type op;
      logic   chan;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic mono;
   } sts_type;

   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [ACC_W-1:0] v
   );
      logic signed [ACC_W-1:0] c;
      priority if (v > SAMPLE_MAX_ACC) c = SAMPLE_MAX_ACC;
      else if (v < SAMPLE_MIN_ACC) c = SAMPLE_MIN_ACC;
      else c = v;
      return c[SAMPLE_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

[rtl/sfdl_ctrl.sv]
// Sequencer for the delay line: clear pass, tap read, four shared-multiplier ops per channel.
`default_nettype none
module sfdl_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire sfdl_pkg::sts_type sts,
   output sfdl_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADDR,
      ST_READ,
      ST_MUL,
      ST_ADD,
      ST_FINISH
   } state_type;

   state_type        state_ff;
   sfdl_pkg::op_type op_ff;
   logic             chan_ff;
   logic             rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.op        = op_ff;
      cmd.chan      = chan_ff;
      unique case (state_ff)
         ST_CLEAR:  cmd.clr_we    = 1'b1;
         ST_IDLE:   cmd.in_load   = req_valid;
         ST_ADDR:   cmd.addr_load = 1'b1;
         ST_READ:   cmd.rd_en     = 1'b1;
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            // store write rides along with the mix multiply
            cmd.wr_en  = (op_ff == sfdl_pkg::OP_MIX);
         end
         ST_ADD:    cmd.add_en    = 1'b1;
         ST_FINISH: cmd.out_load  = !rsp_valid_ff || rsp_ready;
         default:   cmd           = '0;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         op_ff        <= sfdl_pkg::OP_BLEND;
         chan_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_CLEAR: begin
               if (sts.clr_last) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_ADDR;
                  op_ff    <= sfdl_pkg::OP_BLEND;
                  chan_ff  <= 1'b0;
               end
            end
            ST_ADDR:  state_ff <= ST_READ;
            ST_READ:  state_ff <= ST_MUL;
            ST_MUL:   state_ff <= ST_ADD;
            ST_ADD: begin
               unique case (op_ff)
                  sfdl_pkg::OP_BLEND: begin
                     op_ff    <= sfdl_pkg::OP_FEEDBACK;
                     state_ff <= ST_MUL;
                  end
                  sfdl_pkg::OP_FEEDBACK: begin
                     op_ff    <= sfdl_pkg::OP_DAMP;
                     state_ff <= ST_MUL;
                  end
                  sfdl_pkg::OP_DAMP: begin
                     op_ff    <= sfdl_pkg::OP_MIX;
                     state_ff <= ST_MUL;
                  end
                  default: begin
                     if (!chan_ff && !sts.mono) begin
                        chan_ff  <= 1'b1;
                        op_ff    <= sfdl_pkg::OP_BLEND;
                        state_ff <= ST_MUL;
                     end else begin
                        state_ff <= ST_FINISH;
                     end
                  end
               endcase
            end
            ST_FINISH: begin
               if (cmd.out_load) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_CLEAR;
         endcase
      end
   end

endmodule
`default_nettype wire

[rtl/sfdl_datapath.sv]
// Delay memories, configuration registers, shared multiply-accumulate and result register.
`default_nettype none
module sfdl_datapath #(
   parameter int unsigned DELAY_DEPTH = sfdl_pkg::DELAY_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [sfdl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [sfdl_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire sfdl_pkg::req_type                   req_data,
   output sfdl_pkg::rsp_type                        rsp_data,
   input  wire sfdl_pkg::cmd_type                   cmd,
   output sfdl_pkg::sts_type                        sts
);

   localparam int SW      = sfdl_pkg::SAMPLE_BITS;
   localparam int DW      = sfdl_pkg::DAMP_W;
   localparam int AW      = sfdl_pkg::MUL_A_W;
   localparam int BW      = sfdl_pkg::MUL_B_W;
   localparam int PW      = sfdl_pkg::PROD_W;
   localparam int CW      = sfdl_pkg::ACC_W;
   localparam int PTR_W   = $clog2(DELAY_DEPTH);
   localparam int CLAMP_W = (PTR_W + 1 > 17) ? PTR_W + 1 : 17;

   localparam logic [PTR_W-1:0]   LAST_IDX  = PTR_W'(DELAY_DEPTH - 1);
   localparam logic [PTR_W:0]     DEPTH_EXT = (PTR_W + 1)'(DELAY_DEPTH);
   localparam logic [CLAMP_W-1:0] DLY_MAX   = CLAMP_W'(DELAY_DEPTH - 1);

   // configuration
   logic [1:0]  chan_cnt_ff;
   logic [16:0] delay_ff;
   logic [15:0] frac_ff;
   logic [15:0] gain_ff;
   logic [16:0] mix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_cnt_ff <= sfdl_pkg::RST_CHANNEL_COUNT;
         delay_ff    <= sfdl_pkg::RST_DELAY_SAMPLES;
         frac_ff     <= sfdl_pkg::RST_DELAY_FRACTION;
         gain_ff     <= sfdl_pkg::RST_FEEDBACK_GAIN;
         mix_ff      <= sfdl_pkg::RST_WET_MIX;
      end else if (csr_we) begin
         unique case (csr_index)
            sfdl_pkg::CSR_CHANNEL_COUNT:  chan_cnt_ff <= csr_wdata[1:0];
            sfdl_pkg::CSR_DELAY_SAMPLES:  delay_ff    <= csr_wdata[16:0];
            sfdl_pkg::CSR_DELAY_FRACTION: frac_ff     <= csr_wdata[15:0];
            sfdl_pkg::CSR_FEEDBACK_GAIN:  gain_ff     <= csr_wdata[15:0];
            sfdl_pkg::CSR_WET_MIX:        mix_ff      <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   logic                 mono;
   logic [15:0]          gain_eff;
   logic [16:0]          mix_eff;
   logic [CLAMP_W-1:0]   dly_wide;
   logic [PTR_W-1:0]     dly;

   assign mono     = (chan_cnt_ff == sfdl_pkg::CHANNELS_MONO);
   assign gain_eff = (gain_ff > sfdl_pkg::FB_MAX_Q16) ? sfdl_pkg::FB_MAX_Q16 : gain_ff;
   assign mix_eff  = (mix_ff > sfdl_pkg::MIX_ONE_Q16) ? sfdl_pkg::MIX_ONE_Q16 : mix_ff;

   always_comb begin
      dly_wide = CLAMP_W'(delay_ff);
      priority if (dly_wide == '0) dly_wide = CLAMP_W'(1);
      else if (dly_wide > DLY_MAX) dly_wide = DLY_MAX;
      else dly_wide = dly_wide;
   end
   assign dly = dly_wide[PTR_W-1:0];

   // pointers
   logic [PTR_W-1:0] wp_ff;
   logic [PTR_W-1:0] clr_ff;
   logic [PTR_W-1:0] rd_a_ff;
   logic [PTR_W-1:0] rd_b_ff;
   logic [PTR_W:0]   rd_sum;
   logic [PTR_W-1:0] rd_a;
   logic [PTR_W-1:0] rd_b;

   assign rd_sum = {1'b0, wp_ff} + ((wp_ff >= dly) ? '0 : DEPTH_EXT) - {1'b0, dly};
   assign rd_a   = rd_sum[PTR_W-1:0];
   assign rd_b   = (rd_a == LAST_IDX) ? '0 : rd_a + PTR_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         clr_ff <= '0;
      end else begin
         if (cmd.clr_we) clr_ff <= (clr_ff == LAST_IDX) ? '0 : clr_ff + PTR_W'(1);
         if (cmd.out_load) wp_ff <= (wp_ff == LAST_IDX) ? '0 : wp_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.addr_load) begin
         rd_a_ff <= rd_a;
         rd_b_ff <= rd_b;
      end
   end

   assign sts.clr_last = (clr_ff == LAST_IDX);
   assign sts.mono     = mono;

   // per-channel working registers
   sfdl_pkg::req_type     in_ff;
   logic signed [SW-1:0]  tap_a_ff [2];
   logic signed [SW-1:0]  tap_b_ff [2];
   logic signed [SW-1:0]  d_ff     [2];
   logic signed [DW-1:0]  p_ff     [2];
   logic signed [DW-1:0]  s_ff     [2];
   logic signed [SW-1:0]  y_ff     [2];

   always_ff @(posedge clock) begin
      if (cmd.in_load) in_ff <= req_data;
   end

   logic signed [SW-1:0] x_sel;
   assign x_sel = cmd.chan ? in_ff.right_in : in_ff.left_in;

   // store write value: input plus rounded damping state, saturated
   logic signed [CW-1:0] fb_round;
   logic signed [SW-1:0] wr_data;
   logic [PTR_W-1:0]     wr_addr;
   logic                 we_l;
   logic                 we_r;

   assign fb_round = (CW'(s_ff[cmd.chan]) + CW'(128)) >>> sfdl_pkg::DAMP_EXTRA_BITS;
   assign wr_data  = cmd.clr_we ? '0 : sfdl_pkg::sat_sample(CW'(x_sel) + fb_round);
   assign wr_addr  = cmd.clr_we ? clr_ff : wp_ff;
   assign we_l     = cmd.clr_we || (cmd.wr_en && !cmd.chan);
   assign we_r     = cmd.clr_we || (cmd.wr_en && cmd.chan);

   logic [SW-1:0] mem_l [DELAY_DEPTH];
   logic [SW-1:0] mem_r [DELAY_DEPTH];

   // both channel memories: one write port, two registered tap reads each
   always_ff @(posedge clock) begin
      if (we_l) mem_l[wr_addr] <= wr_data;
      if (we_r) mem_r[wr_addr] <= wr_data;
      if (cmd.rd_en) begin
         tap_a_ff[0] <= mem_l[rd_a_ff];
         tap_b_ff[0] <= mem_l[rd_b_ff];
         tap_a_ff[1] <= mem_r[rd_a_ff];
         tap_b_ff[1] <= mem_r[rd_b_ff];
      end
   end

   // multiply stage: acc = base * 2^sh + A * B, result = round(acc / 2^sh)
   logic signed [AW-1:0] op_a;
   logic signed [BW-1:0] op_b;
   logic signed [CW-1:0] op_base;
   logic signed [PW-1:0] prod_ff;
   logic signed [CW-1:0] base_ff;
   sfdl_pkg::op_type     op_ff;
   logic                 chan_ff;

   always_comb begin
      unique case (cmd.op)
         sfdl_pkg::OP_BLEND: begin
            op_a    = AW'(tap_b_ff[cmd.chan]) - AW'(tap_a_ff[cmd.chan]);
            op_b    = BW'({2'b00, frac_ff});
            op_base = CW'(tap_a_ff[cmd.chan]);
         end
         sfdl_pkg::OP_FEEDBACK: begin
            op_a    = AW'(d_ff[cmd.chan]);
            op_b    = BW'({2'b00, gain_eff});
            op_base = '0;
         end
         sfdl_pkg::OP_DAMP: begin
            // 0.7 s + 0.3 p  ==  s + 0.3 (p - s)
            op_a    = AW'(p_ff[cmd.chan]) - AW'(s_ff[cmd.chan]);
            op_b    = BW'({2'b00, sfdl_pkg::DAMP_NEW_Q16});
            op_base = CW'(s_ff[cmd.chan]);
         end
         default: begin
            op_a    = AW'(d_ff[cmd.chan]) - AW'(x_sel);
            op_b    = BW'({1'b0, mix_eff});
            op_base = CW'(x_sel);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= op_a * op_b;
         base_ff <= op_base;
         op_ff   <= cmd.op;
         chan_ff <= cmd.chan;
      end
   end

   // accumulate stage
   logic                 short_sh;
   logic signed [CW-1:0] acc;
   logic signed [CW-1:0] res;

   assign short_sh = (op_ff == sfdl_pkg::OP_FEEDBACK);
   assign acc      = (base_ff <<< 16) + CW'(prod_ff)
                     + (short_sh ? CW'(128) : CW'(32768));
   assign res      = short_sh ? (acc >>> 8) : (acc >>> 16);

   always_ff @(posedge clock) begin
      if (cmd.add_en) begin
         unique case (op_ff)
            sfdl_pkg::OP_BLEND:    d_ff[chan_ff] <= res[SW-1:0];
            sfdl_pkg::OP_FEEDBACK: p_ff[chan_ff] <= res[DW-1:0];
            sfdl_pkg::OP_DAMP:     ;
            default:               y_ff[chan_ff] <= sfdl_pkg::sat_sample(res);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff[0] <= '0;
         s_ff[1] <= '0;
      end else if (cmd.add_en && (op_ff == sfdl_pkg::OP_DAMP)) begin
         s_ff[chan_ff] <= res[DW-1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data.left_out  <= y_ff[0];
         rsp_data.right_out <= mono ? in_ff.right_in : y_ff[1];
      end
   end

endmodule
`default_nettype wire

[rtl/stereo_feedback_delay_line_core.sv]
// Top level of the stereo feedback delay line: sequencer plus datapath.
// Stereo feedback delay with linear tap interpolation and one-pole damping.
// One transfer on req_ carries a stereo Q1.15 frame; one transfer on rsp_
// returns the dry/wet mix. After reset the block sweeps all DELAY_DEPTH entries
// (131072 by default) of both delay memories to zero, one entry per cycle;
// req_ready stays low during that sweep, csr_ writes are taken as ever.
// Frames are processed one at a time through a single shared 25x18
// multiplier with a registered product and a separate accumulate cycle, so
// each of the four operations per channel (tap blend, feedback scale,
// damping, mix) takes a multiply state and then an accumulate state. A frame
// goes through accept, address load, tap read, the op pairs of each channel
// and the result register load. A finished result is held in the rsp_
// register; while it waits, the next frame is accepted and worked on, and
// only its final load waits for the slot to free up. Registers (csr_index):
// 0 channel_count, 1 delay_samples, 2 delay_fraction, 3 feedback_gain,
// 4 wet_mix; write them only while the block is idle.
`default_nettype none
module stereo_feedback_delay_line_core #(
   parameter int unsigned DELAY_DEPTH = sfdl_pkg::DELAY_DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input frames
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire sfdl_pkg::req_type               req_data,
   // mixed output frames
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output sfdl_pkg::rsp_type                    rsp_data,
   // configuration writes
   input  wire logic                            csr_we,
   input  wire logic [sfdl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sfdl_pkg::CSR_DATA_W-1:0] csr_wdata
);

   sfdl_pkg::cmd_type cmd;
   sfdl_pkg::sts_type sts;

   // control: clear sweep, op sequencing, rsp_valid
   sfdl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // data: memories, config, shared MAC, output register
   sfdl_datapath #(
      .DELAY_DEPTH (DELAY_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

`ifndef SYNTHESIS
   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("result register loaded while previous result pending");

   // one frame in flight: ready drops right after an accepted transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second frame accepted while one is in flight");

   // clear sweep shuts the input and has no result pending
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_we |-> (!req_ready && !rsp_valid && !cmd.wr_en))
      else $error("activity during memory clear sweep");
`endif

endmodule
`default_nettype wire
